@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/b64_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 codec package
// Shared types, constants and alphabet functions for the streaming codec.
// ----------------------------------------------------------------------------
package b64_pkg;

    localparam int GROUP_W = 24;
    localparam int SIX_W   = 6;
    localparam int BYTE_W  = 8;

    localparam logic [2:0] ENC_RESULTS = 3'd4;
    localparam logic [2:0] DEC_RESULTS = 3'd3;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [SIX_W-1:0]  t_six;

    // A completed group handed from the packer to the emitter.
    typedef struct packed {
        logic [GROUP_W-1:0] bits;
        logic               decode;
        logic               last;
    } t_group;

    // Maps a 6-bit index to its character in the standard alphabet.
    function automatic t_byte six_to_char(input t_six idx);
        t_byte wide;
        wide = {2'b00, idx};
        if (idx < 6'd26) begin
            return wide + 8'h41;
        end else if (idx < 6'd52) begin
            return wide - 8'd26 + 8'h61;
        end else if (idx < 6'd62) begin
            return wide - 8'd52 + 8'h30;
        end else if (idx == 6'd62) begin
            return 8'h2B;
        end else begin
            return 8'h2F;
        end
    endfunction

    // Maps a character to its 6-bit index; characters outside the alphabet map to zero.
    function automatic t_six char_to_six(input t_byte c);
        t_byte v;
        v = 8'h00;
        if (c >= 8'h41 && c <= 8'h5A) begin
            v = c - 8'h41;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = c - 8'h61 + 8'd26;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30 + 8'd52;
        end else if (c == 8'h2B) begin
            v = 8'd62;
        end else if (c == 8'h2F) begin
            v = 8'd63;
        end
        return v[SIX_W-1:0];
    endfunction

endpackage

@@ rtl/b64_pack.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 group packer
// Holds the mode register and the partial group, and hands complete groups on.
// ----------------------------------------------------------------------------
module b64_pack (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_valid,
    input  b64_pkg::t_byte    i_in_byte,
    input  logic              i_in_last,
    output logic              o_stall,
    input  logic              i_emit_free,
    output logic              o_grp_valid,
    output b64_pkg::t_group   o_grp
);
    import b64_pkg::*;

    logic               r_mode;
    logic [GROUP_W-1:0] r_bits;
    logic [1:0]         r_count;
    logic [GROUP_W-1:0] n_bits;
    logic [1:0]         n_count;
    logic [GROUP_W-1:0] merged;
    logic               complete;
    logic               accept;
    t_six               idx;

    assign idx = char_to_six(i_in_byte);

    always_comb begin
        merged = r_bits;
        if (!r_mode) begin
            unique case (r_count)
                2'd0:    merged = r_bits | {i_in_byte, 16'h0000};
                2'd1:    merged = r_bits | {8'h00, i_in_byte, 8'h00};
                2'd2:    merged = r_bits | {16'h0000, i_in_byte};
                default: merged = {i_in_byte, 16'h0000};
            endcase
            complete = (r_count == 2'd2) || i_in_last;
        end else begin
            unique case (r_count)
                2'd0:    merged = r_bits | {idx, 18'h00000};
                2'd1:    merged = r_bits | {6'h00, idx, 12'h000};
                2'd2:    merged = r_bits | {12'h000, idx, 6'h00};
                default: merged = r_bits | {18'h00000, idx};
            endcase
            complete = (r_count == 2'd3);
        end
    end

    assign o_stall     = complete && !i_emit_free;
    assign accept      = i_valid && !o_stall;
    assign o_grp_valid = accept && complete;
    assign o_grp       = '{bits: merged, decode: r_mode, last: i_in_last};

    always_comb begin
        n_bits  = r_bits;
        n_count = r_count;
        if (accept) begin
            if (complete || i_in_last) begin
                n_bits  = '0;
                n_count = 2'd0;
            end else begin
                n_bits  = merged;
                n_count = (!r_mode && r_count == 2'd3) ? 2'd1 : r_count + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_bits  <= '0;
            r_count <= 2'd0;
        end else if (i_cfg_we) begin
            r_mode  <= i_cfg_wdata;
            r_bits  <= '0;
            r_count <= 2'd0;
        end else begin
            r_bits  <= n_bits;
            r_count <= n_count;
        end
    end

endmodule

@@ rtl/b64_emit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 result emitter
// Holds one complete group and sends its characters or bytes one per cycle unless stalled.
// ----------------------------------------------------------------------------
module b64_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_grp_valid,
    input  b64_pkg::t_group   i_grp,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_stall,
    output b64_pkg::t_byte    o_out_byte,
    output logic              o_run_last,
    output logic              o_stream_end
);
    import b64_pkg::*;

    logic [GROUP_W-1:0] r_bits;
    logic [2:0]         r_left;
    logic               r_decode;
    logic               r_last;
    logic               taken;

    assign o_valid      = (r_left != 3'd0);
    assign taken        = o_valid && !i_stall;
    assign o_free       = !o_valid || (taken && r_left == 3'd1);
    assign o_run_last   = (r_left == 3'd1);
    assign o_stream_end = r_last;
    assign o_out_byte   = r_decode ? r_bits[GROUP_W-1 -: BYTE_W]
                                   : six_to_char(r_bits[GROUP_W-1 -: SIX_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
        end else if (i_grp_valid) begin
            r_left <= i_grp.decode ? DEC_RESULTS : ENC_RESULTS;
        end else if (taken) begin
            r_left <= r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_grp_valid) begin
            r_bits   <= i_grp.bits;
            r_decode <= i_grp.decode;
            r_last   <= i_grp.last;
        end else if (taken) begin
            r_bits <= r_decode ? {r_bits[GROUP_W-BYTE_W-1:0], {BYTE_W{1'b0}}}
                               : {r_bits[GROUP_W-SIX_W-1:0], {SIX_W{1'b0}}};
        end
    end

endmodule

@@ rtl/base64_stream_codec_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 stream codec core
// Encodes bytes to Base64 characters or decodes characters to bytes.
// ----------------------------------------------------------------------------
// Input requests are packed into a group register with no wait; the request that
// completes a group hands it to a result register that drains one result per
// unstalled cycle, and that hand-off waits only while the previous group drains.
// Unstalled, encoding gives four characters per group of three input bytes
// through the single result port, and decoding sustains one
// character per cycle. Writing the mode register clears any partial group.
module base64_stream_codec_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_in_byte,
    input  logic                i_in_last,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [7:0]          o_out_byte,
    output logic                o_run_last,
    output logic                o_stream_end
);
    import b64_pkg::*;

`include "assert_macros.svh"

    logic   grp_valid;
    t_group grp;
    logic   emit_free;
    logic   run_done;
    logic   run_mid;

    b64_pack u_pack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_stall     (o_stall),
        .i_emit_free (emit_free),
        .o_grp_valid (grp_valid),
        .o_grp       (grp)
    );

    b64_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_grp_valid  (grp_valid),
        .i_grp        (grp),
        .o_free       (emit_free),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_stream_end (o_stream_end)
    );

    assign run_done = o_valid && !i_stall && o_run_last && !grp_valid;
    assign run_mid  = o_valid && !i_stall && !o_run_last;

    // A group is only handed over when the result register can take it.
    `ASSERT_CLK(a_load_when_free, i_clk, i_rst_n, !grp_valid || emit_free, "group lost")
    // After the final result of a group leaves with no new group, the output goes idle.
    `ASSERT_NEXT(a_idle_after_run, i_clk, i_rst_n, run_done, !o_valid, "extra result")
    // A result that is not the final one of its group is followed by another.
    `ASSERT_NEXT(a_run_continues, i_clk, i_rst_n, run_mid, o_valid, "run cut short")
    `ASSERT_NEXT(a_end_stable, i_clk, i_rst_n, run_mid, $stable(o_stream_end), "end flag moved")

endmodule

@@ verif/base64_stream_codec_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 stream codec core testbench
// Drives byte and character streams through the codec in both directions,
// predicts every output character or byte in a scoreboard, and compares the
// results field by field under random idling and stalls on both channels.
// ----------------------------------------------------------------------------
module base64_stream_codec_core_tb;

    import b64_pkg::*;

    localparam int RANDOM_ITEMS = 130;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 150;
    localparam int HOLD_ITEMS   = 24;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        t_byte out_byte;
        logic  run_last;
        logic  stream_end;
    } t_b64_result;

    class b64_result_board;
        string              alphabet;
        logic               decode_mode;
        logic [GROUP_W-1:0] group_bits;
        logic [1:0]         group_count;
        t_b64_result        expected_q[$];
        int                 errors;

        function new();
            alphabet    = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
            decode_mode = 1'b0;
            group_bits  = '0;
            group_count = '0;
            errors      = 0;
        endfunction

        function void write_mode(logic mode);
            decode_mode = mode;
            group_bits  = '0;
            group_count = '0;
        endfunction

        function t_six char_value(t_byte c);
            for (int i = 0; i < 64; i++) begin
                if (t_byte'(alphabet[i]) == c) begin
                    return t_six'(i);
                end
            end
            return '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Updates the group with one accepted request and queues its results.
        function void note_request(t_byte data, logic last);
            int unsigned cnt;
            int unsigned shift;
            t_b64_result r;
            cnt = group_count;
            if (!decode_mode) begin
                if (cnt > 2) begin
                    cnt        = 0;
                    group_bits = '0;
                end
                shift      = (2 - cnt) * 8;
                group_bits = group_bits | (GROUP_W'(data) << shift);
                cnt++;
                if (cnt == 3 || last) begin
                    for (int k = 0; k < 4; k++) begin
                        r.out_byte   = t_byte'(alphabet[group_bits[GROUP_W-1-6*k -: SIX_W]]);
                        r.run_last   = (k == 3);
                        r.stream_end = last;
                        expected_q   = {expected_q, r};
                    end
                    group_bits = '0;
                    cnt        = 0;
                end
            end else begin
                shift      = (3 - cnt) * 6;
                group_bits = group_bits | (GROUP_W'(char_value(data)) << shift);
                if (cnt == 3) begin
                    for (int k = 0; k < 3; k++) begin
                        r.out_byte   = group_bits[GROUP_W-1-8*k -: BYTE_W];
                        r.run_last   = (k == 2);
                        r.stream_end = last;
                        expected_q   = {expected_q, r};
                    end
                    group_bits = '0;
                    cnt        = 0;
                end else begin
                    cnt++;
                end
                if (last) begin
                    group_bits = '0;
                    cnt        = 0;
                end
            end
            group_count = 2'(cnt);
        endfunction

        function void check_result(t_byte out_byte, logic run_last, logic stream_end);
            t_b64_result want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: out_byte=%02h run_last=%0b stream_end=%0b",
                       out_byte, run_last, stream_end);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (out_byte !== want.out_byte) begin
                $error("out_byte mismatch: expected %02h, actual %02h", want.out_byte, out_byte);
                errors++;
            end
            if (run_last !== want.run_last) begin
                $error("run_last mismatch: expected %0b, actual %0b", want.run_last, run_last);
                errors++;
            end
            if (stream_end !== want.stream_end) begin
                $error("stream_end mismatch: expected %0b, actual %0b",
                       want.stream_end, stream_end);
                errors++;
            end
        endfunction
    endclass

    logic  i_clk       = 1'b0;
    logic  i_rst_n     = 1'b0;
    logic  i_cfg_we    = 1'b0;
    logic  i_cfg_wdata = 1'b0;
    logic  i_valid     = 1'b0;
    logic  o_stall;
    t_byte i_in_byte   = '0;
    logic  i_in_last   = 1'b0;
    logic  o_valid;
    logic  i_stall     = 1'b0;
    t_byte o_out_byte;
    logic  o_run_last;
    logic  o_stream_end;

    b64_result_board board = new();

    int   cycle_count  = 0;
    int   random_items = 0;
    logic allow_gaps   = 1'b1;
    logic calm         = 1'b0;
    logic hold_long    = 1'b0;
    logic hold_taken   = 1'b0;
    logic rx_holding   = 1'b0;
    logic hold_done    = 1'b0;

    base64_stream_codec_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_stream_end (o_stream_end)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_result(o_out_byte, o_run_last, o_stream_end);
        end
    end

    initial begin
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_long && !hold_taken) begin
                hold_taken = 1'b1;
                rx_holding = 1'b1;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                rx_holding = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(0, 18)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                repeat ($urandom_range(0, 18)) @(posedge i_clk);
            end
        end
    end

    task automatic send_request(t_byte data, logic last);
        int unsigned gap;
        if (allow_gaps && !calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= data;
        i_in_last <= last;
        do @(posedge i_clk); while (o_stall);
        board.note_request(data, last);
    endtask

    task automatic send_text(string text, logic last);
        for (int i = 0; i < text.len(); i++) begin
            send_request(t_byte'(text[i]), last && (i == text.len() - 1));
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(logic mode);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.write_mode(mode);
    endtask

    // Decode streams are mostly alphabet characters, with some arbitrary bytes mixed in.
    task automatic run_stream();
        int unsigned len;
        t_byte       data;
        if (!board.decode_mode) begin
            len = $urandom_range(1, 10);
        end else if ($urandom_range(0, 3) != 0) begin
            len = 4 * $urandom_range(1, 3);
        end else begin
            len = $urandom_range(1, 11);
        end
        for (int i = 0; i < len; i++) begin
            if (!board.decode_mode || $urandom_range(0, 6) == 0) begin
                data = t_byte'($urandom_range(0, 255));
            end else begin
                data = t_byte'(board.alphabet[$urandom_range(0, 63)]);
            end
            send_request(data, i == len - 1);
            random_items++;
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_mode(1'b0);
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(8'h80, 1'b0);
        send_request(8'hFF, 1'b1);
        send_request(8'h01, 1'b0);
        send_request(8'hFE, 1'b1);
        send_text("Man", 1'b1);
        wait_drained();

        write_mode(1'b1);
        send_text("TWFu", 1'b0);
        send_text("+/9z", 1'b0);
        send_request(8'h3D, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(8'h00, 1'b0);
        send_request(8'h40, 1'b1);
        send_text("QQ", 1'b1);
        send_text("QU", 1'b0);
        wait_drained();
        write_mode(1'b0);

        while (random_items < RANDOM_ITEMS) begin
            if (!hold_done && random_items >= 40) begin
                wait_drained();
                write_mode(1'b0);
                allow_gaps = 1'b0;
                hold_long  = 1'b1;
                wait (rx_holding);
                for (int i = 0; i < HOLD_ITEMS; i++) begin
                    send_request(t_byte'($urandom_range(0, 255)), i == HOLD_ITEMS - 1);
                end
                random_items += HOLD_ITEMS;
                allow_gaps = 1'b1;
                hold_done  = 1'b1;
            end else begin
                wait_drained();
                write_mode(1'($urandom_range(0, 1)));
                repeat ($urandom_range(1, 4)) run_stream();
            end
            if (random_items >= 3 * RANDOM_ITEMS / 4) begin
                calm = 1'b1;
            end
        end

        wait_drained();
        if (board.errors == 0 && board.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
